// ===== hdl/plob_pkg.sv =====
// Shared types and constants for the price-level order book.
package plob_pkg;

    localparam int PRICE_W = 7;
    localparam int QTY_W   = 32;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_LOAD      = 3'd1,
        OP_DELTA     = 3'd2,
        OP_TRADE     = 3'd3,
        OP_TOP_BIDS  = 3'd4,
        OP_TOP_ASKS  = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]        op;
        logic              side;
        logic [7:0]        bid_price;
        logic [7:0]        ask_price;
        logic [31:0]       qty;
        logic signed [31:0] amount;
    } t_in_word;

    typedef struct packed {
        logic               status;
        logic               level_valid;
        logic [PRICE_W-1:0] level_price;
        logic [QTY_W-1:0]   level_qty;
        logic               best_bid_valid;
        logic [PRICE_W-1:0] best_bid_price;
        logic [QTY_W-1:0]   best_bid_qty;
        logic               best_ask_valid;
        logic [PRICE_W-1:0] best_ask_price;
        logic [QTY_W-1:0]   best_ask_qty;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic               bid_valid;
        logic [PRICE_W-1:0] bid_price;
        logic               ask_valid;
        logic [PRICE_W-1:0] ask_price;
    } t_best;

endpackage

// ===== hdl/plob_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
module plob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/plob_best.sv =====
// Two-stage registered search for the highest set bid and the lowest set ask.
module plob_best import plob_pkg::*; #(
    parameter int PRICE_LEVELS = 128
) (
    input  logic                    i_clk,
    input  logic [PRICE_LEVELS-1:0] i_bid_map,
    input  logic [PRICE_LEVELS-1:0] i_ask_map,
    output t_best                   o_best
);

    localparam int GROUP_W = 8;
    localparam int NG      = (PRICE_LEVELS + GROUP_W - 1) / GROUP_W;

    logic [NG*GROUP_W-1:0] w_bid_pad;
    logic [NG*GROUP_W-1:0] w_ask_pad;
    logic                  w_bany [NG];
    logic                  w_aany [NG];
    logic [2:0]            w_bsub [NG];
    logic [2:0]            w_asub [NG];
    logic                  r_bany [NG];
    logic                  r_aany [NG];
    logic [2:0]            r_bsub [NG];
    logic [2:0]            r_asub [NG];
    t_best                 w_best;
    t_best                 r_best;

    assign w_bid_pad = (NG*GROUP_W)'(i_bid_map);
    assign w_ask_pad = (NG*GROUP_W)'(i_ask_map);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            w_bany[g] = |w_bid_pad[g*GROUP_W +: GROUP_W];
            w_aany[g] = |w_ask_pad[g*GROUP_W +: GROUP_W];
            w_bsub[g] = '0;
            w_asub[g] = '0;
            for (int b = 0; b < GROUP_W; b++) begin
                if (w_bid_pad[g*GROUP_W + b]) begin
                    w_bsub[g] = 3'(b);
                end
            end
            for (int b = GROUP_W - 1; b >= 0; b--) begin
                if (w_ask_pad[g*GROUP_W + b]) begin
                    w_asub[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NG; g++) begin
            r_bany[g] <= w_bany[g];
            r_aany[g] <= w_aany[g];
            r_bsub[g] <= w_bsub[g];
            r_asub[g] <= w_asub[g];
        end
        r_best <= w_best;
    end

    always_comb begin
        w_best = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_bany[g]) begin
                w_best.bid_valid = 1'b1;
                w_best.bid_price = PRICE_W'(g*GROUP_W + int'(r_bsub[g]));
            end
        end
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_aany[g]) begin
                w_best.ask_valid = 1'b1;
                w_best.ask_price = PRICE_W'(g*GROUP_W + int'(r_asub[g]));
            end
        end
    end

    assign o_best = r_best;

endmodule

// ===== hdl/price_level_order_book_top.sv =====
// Top level of the two-sided price-level order book with nonempty bitmaps.
// Each side holds its quantities in one memory with a single read port, and a
// flop per price marks entries written since the last clear. A delta or trade
// word that changes a level goes from acceptance to its result in these steps:
// decode and read, read-modify-write the level, the registered best-price
// search, reading the best quantities and loading the result register. Clear,
// load level and ignored words skip the read-modify-write. A top-N query first
// finds the best prices, then scans the prices in order, with its own memory
// read for each reported level, then sees the end of the scan and loads the
// final result; a result that waits at the output holds the scan back. The
// block takes a new word only in the cycle after the previous one has finished,
// while its final result may still wait at the output.
module price_level_order_book_top import plob_pkg::*; #(
    parameter int PRICE_LEVELS = 128,
    parameter int MAX_DEPTH    = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int AW = $clog2(PRICE_LEVELS);
    localparam int IW = AW + 1;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [8:0]  LEVELS_L = 9'(PRICE_LEVELS);
    localparam logic [31:0] DEPTH_L  = 32'(MAX_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_MOD, S_TREE, S_TREE2, S_BEST, S_BQ, S_SCAN, S_LVL, S_FIN
    } t_state;

    t_state                  r_state;
    t_in_word                r_item;
    logic                    r_status;
    logic [DW-1:0]           r_n;
    logic [DW-1:0]           r_cnt;
    logic [IW-1:0]           r_idx;
    logic                    r_tgt_ask;
    logic [AW-1:0]           r_addr;
    logic [AW-1:0]           r_lvl_addr;
    logic [PRICE_LEVELS-1:0] r_bid_map;
    logic [PRICE_LEVELS-1:0] r_ask_map;
    logic [PRICE_LEVELS-1:0] r_bid_vld;
    logic [PRICE_LEVELS-1:0] r_ask_vld;
    logic                    r_bid_rvld;
    logic                    r_ask_rvld;
    logic                    r_bb_valid;
    logic [PRICE_W-1:0]      r_bb_price;
    logic [QTY_W-1:0]        r_bb_qty;
    logic                    r_ba_valid;
    logic [PRICE_W-1:0]      r_ba_price;
    logic [QTY_W-1:0]        r_ba_qty;
    logic                    r_pend_valid;
    logic [PRICE_W-1:0]      r_pend_price;
    logic [QTY_W-1:0]        r_pend_qty;
    logic                    r_out_valid;
    t_out_word               r_out_word;

    t_best            w_best;
    logic             w_tgt_ask;
    logic [7:0]       w_tgt_price;
    logic             w_price_ok;
    logic [AW-1:0]    w_tgt_addr;
    logic             w_amt_pos;
    logic             w_rmw_go;
    logic [QTY_W-1:0] w_bid_rdata;
    logic [QTY_W-1:0] w_ask_rdata;
    logic [QTY_W-1:0] w_q_bid;
    logic [QTY_W-1:0] w_q_ask;
    logic [QTY_W-1:0] w_old;
    logic [QTY_W-1:0] w_new;
    logic             w_scan_bid;
    logic [AW-1:0]    w_scan_addr;
    logic             w_scan_hit;
    logic             w_scan_end;
    logic             w_out_free;
    logic             w_out_load;
    logic             w_bid_we;
    logic             w_ask_we;
    logic [AW-1:0]    w_waddr;
    logic [QTY_W-1:0] w_wdata;
    logic             w_bid_re;
    logic             w_ask_re;
    logic [AW-1:0]    w_bid_raddr;
    logic [AW-1:0]    w_ask_raddr;
    logic             w_load_go;
    t_out_word        w_pend_word;
    t_out_word        w_final_word;
    t_out_word        w_empty_word;

    assign w_tgt_ask   = (r_item.op == OP_TRADE) ? ~r_item.side : r_item.side;
    assign w_tgt_price = w_tgt_ask ? r_item.ask_price : r_item.bid_price;
    assign w_price_ok  = {1'b0, w_tgt_price} < LEVELS_L;
    assign w_tgt_addr  = w_tgt_price[AW-1:0];
    assign w_amt_pos   = !r_item.amount[31] && (r_item.amount != 32'sd0);
    assign w_rmw_go    = w_price_ok &&
                         ((r_item.op == OP_DELTA) || ((r_item.op == OP_TRADE) && w_amt_pos));
    assign w_load_go   = (r_state == S_EXEC) && (r_item.op == OP_LOAD) && w_price_ok;

    assign w_q_bid = r_bid_rvld ? w_bid_rdata : '0;
    assign w_q_ask = r_ask_rvld ? w_ask_rdata : '0;
    assign w_old   = r_tgt_ask ? w_q_ask : w_q_bid;
    assign w_new   = (r_item.op == OP_DELTA) ? w_old + $unsigned(r_item.amount)
                                             : w_old - $unsigned(r_item.amount);

    assign w_scan_bid  = (r_item.op == OP_TOP_BIDS);
    assign w_scan_addr = w_scan_bid ? AW'(PRICE_LEVELS - 1) - r_idx[AW-1:0] : r_idx[AW-1:0];
    assign w_scan_hit  = w_scan_bid ? r_bid_map[w_scan_addr] : r_ask_map[w_scan_addr];
    assign w_scan_end  = (r_idx == IW'(PRICE_LEVELS)) || (r_cnt == r_n);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_load  = w_out_free &&
                         (((r_state == S_LVL) && r_pend_valid) || (r_state == S_FIN));

    assign w_bid_we = (w_load_go && !w_tgt_ask) || ((r_state == S_MOD) && !r_tgt_ask);
    assign w_ask_we = (w_load_go && w_tgt_ask) || ((r_state == S_MOD) && r_tgt_ask);
    assign w_waddr  = (r_state == S_MOD) ? r_addr : w_tgt_addr;
    assign w_wdata  = (r_state == S_MOD) ? w_new : r_item.qty;

    always_comb begin
        w_bid_re    = 1'b0;
        w_ask_re    = 1'b0;
        w_bid_raddr = '0;
        w_ask_raddr = '0;
        unique case (r_state)
            S_EXEC: begin
                w_bid_re    = w_rmw_go && !w_tgt_ask;
                w_ask_re    = w_rmw_go && w_tgt_ask;
                w_bid_raddr = w_tgt_addr;
                w_ask_raddr = w_tgt_addr;
            end
            S_BEST: begin
                w_bid_re    = 1'b1;
                w_ask_re    = 1'b1;
                w_bid_raddr = w_best.bid_price[AW-1:0];
                w_ask_raddr = w_best.ask_price[AW-1:0];
            end
            S_SCAN: begin
                w_bid_re    = !w_scan_end && w_scan_hit && w_scan_bid;
                w_ask_re    = !w_scan_end && w_scan_hit && !w_scan_bid;
                w_bid_raddr = w_scan_addr;
                w_ask_raddr = w_scan_addr;
            end
            default: begin
                w_bid_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_empty_word                = '0;
        w_empty_word.best_bid_valid = r_bb_valid;
        w_empty_word.best_bid_price = r_bb_price;
        w_empty_word.best_bid_qty   = r_bb_qty;
        w_empty_word.best_ask_valid = r_ba_valid;
        w_empty_word.best_ask_price = r_ba_price;
        w_empty_word.best_ask_qty   = r_ba_qty;
        w_empty_word.status         = r_status;
        w_empty_word.last           = 1'b1;
        w_pend_word                 = w_empty_word;
        w_pend_word.status          = 1'b0;
        w_pend_word.level_valid     = 1'b1;
        w_pend_word.level_price     = r_pend_price;
        w_pend_word.level_qty       = r_pend_qty;
        w_pend_word.last            = 1'b0;
        w_final_word                = w_pend_word;
        w_final_word.last           = 1'b1;
    end

    plob_ram #(.WIDTH(QTY_W), .DEPTH(PRICE_LEVELS)) u_bid_ram (
        .i_clk   (i_clk),
        .i_we    (w_bid_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_bid_re),
        .i_raddr (w_bid_raddr),
        .o_rdata (w_bid_rdata)
    );

    plob_ram #(.WIDTH(QTY_W), .DEPTH(PRICE_LEVELS)) u_ask_ram (
        .i_clk   (i_clk),
        .i_we    (w_ask_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_ask_re),
        .i_raddr (w_ask_raddr),
        .o_rdata (w_ask_rdata)
    );

    plob_best #(.PRICE_LEVELS(PRICE_LEVELS)) u_best (
        .i_clk     (i_clk),
        .i_bid_map (r_bid_map),
        .i_ask_map (r_ask_map),
        .o_best    (w_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bid_map    <= '0;
            r_ask_map    <= '0;
            r_bid_vld    <= '0;
            r_ask_vld    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_bid_re) begin
                r_bid_rvld <= r_bid_vld[w_bid_raddr];
            end
            if (w_ask_re) begin
                r_ask_rvld <= r_ask_vld[w_ask_raddr];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item       <= i_in_word;
                        r_status     <= 1'b0;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_tgt_ask <= w_tgt_ask;
                    r_addr    <= w_tgt_addr;
                    unique case (r_item.op)
                        OP_CLEAR: begin
                            r_bid_map <= '0;
                            r_ask_map <= '0;
                            r_bid_vld <= '0;
                            r_ask_vld <= '0;
                            r_state   <= S_TREE;
                        end
                        OP_LOAD: begin
                            r_state <= S_TREE;
                            if (!w_price_ok) begin
                                r_status <= 1'b1;
                            end else if (w_tgt_ask) begin
                                r_ask_vld[w_tgt_addr] <= 1'b1;
                                if (r_item.qty != '0) begin
                                    r_ask_map[w_tgt_addr] <= 1'b1;
                                end
                            end else begin
                                r_bid_vld[w_tgt_addr] <= 1'b1;
                                if (r_item.qty != '0) begin
                                    r_bid_map[w_tgt_addr] <= 1'b1;
                                end
                            end
                        end
                        OP_DELTA, OP_TRADE: begin
                            if (w_rmw_go) begin
                                r_state <= S_MOD;
                            end else begin
                                r_status <= 1'b1;
                                r_state  <= S_TREE;
                            end
                        end
                        OP_TOP_BIDS, OP_TOP_ASKS: begin
                            r_status <= 1'b0;
                            r_state  <= S_TREE;
                        end
                        default: begin
                            r_status <= 1'b1;
                            r_state  <= S_TREE;
                        end
                    endcase
                end
                S_MOD: begin
                    if (r_tgt_ask) begin
                        r_ask_vld[r_addr] <= 1'b1;
                        if (r_item.op == OP_DELTA) begin
                            r_ask_map[r_addr] <= (w_new != '0);
                        end else if (w_new == '0) begin
                            r_ask_map[r_addr] <= 1'b0;
                        end
                    end else begin
                        r_bid_vld[r_addr] <= 1'b1;
                        if (r_item.op == OP_DELTA) begin
                            r_bid_map[r_addr] <= (w_new != '0);
                        end else if (w_new == '0) begin
                            r_bid_map[r_addr] <= 1'b0;
                        end
                    end
                    r_state <= S_TREE;
                end
                S_TREE: begin
                    r_state <= S_TREE2;
                end
                S_TREE2: begin
                    r_state <= S_BEST;
                end
                S_BEST: begin
                    r_state <= S_BQ;
                end
                S_BQ: begin
                    r_bb_valid <= w_best.bid_valid;
                    r_bb_price <= w_best.bid_price;
                    r_bb_qty   <= w_best.bid_valid ? w_q_bid : '0;
                    r_ba_valid <= w_best.ask_valid;
                    r_ba_price <= w_best.ask_price;
                    r_ba_qty   <= w_best.ask_valid ? w_q_ask : '0;
                    r_idx      <= '0;
                    r_cnt      <= '0;
                    r_n        <= ($unsigned(r_item.amount) > DEPTH_L) ? DW'(MAX_DEPTH)
                                                                        : DW'(r_item.amount);
                    if ((r_item.op == OP_TOP_BIDS) || (r_item.op == OP_TOP_ASKS)) begin
                        if (w_amt_pos) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_status <= 1'b1;
                            r_state  <= S_FIN;
                        end
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SCAN: begin
                    if (w_scan_end) begin
                        r_state <= S_FIN;
                    end else if (w_scan_hit) begin
                        r_lvl_addr <= w_scan_addr;
                        r_state    <= S_LVL;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_LVL: begin
                    if (!r_pend_valid || w_out_free) begin
                        if (r_pend_valid) begin
                            r_out_word <= w_pend_word;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend_price <= PRICE_W'(r_lvl_addr);
                        r_pend_qty   <= w_scan_bid ? w_q_bid : w_q_ask;
                        r_cnt        <= r_cnt + DW'(1);
                        r_idx        <= r_idx + IW'(1);
                        r_state      <= S_SCAN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_word   <= r_pend_valid ? w_final_word : w_empty_word;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_map_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_bid_map & ~r_bid_vld) == '0) && ((r_ask_map & ~r_ask_vld) == '0))
        else $error("A nonempty price is marked for an entry never written.");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_LVL)) |-> (r_cnt <= r_n))
        else $error("More levels found than the requested depth.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input taken again before the previous word finished.");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> ((r_state == S_SCAN) || (r_state == S_LVL) || (r_state == S_FIN)))
        else $error("A pending level outlived its query.");

    a_level_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.level_valid) |-> !o_out_word.status)
        else $error("A reported level carries an ignored status.");
`endif

endmodule

// ===== sim/tb_price_level_order_book_top.sv =====
// Self-checking testbench for the price-level order book: directed script, then random traffic.
module tb_price_level_order_book_top;
    import plob_pkg::*;

    localparam int LEVELS       = 128;
    localparam int DEPTH_CAP    = 64;
    localparam int RANDOM_ITEMS = 190;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE       = 32;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic        side;
        logic [7:0]  bid_price;
        logic [7:0]  ask_price;
        logic [31:0] qty;
        logic [31:0] amount;
        logic        typed;
        logic        typed_status;
    } t_stim_row;

    t_stim_row book_script [0:26] = '{
        '{OP_TOP_BIDS, 1'b0, 8'd0,   8'd0,   32'd0,          32'd5,          1'b1, 1'b0},
        '{OP_TOP_ASKS, 1'b1, 8'd255, 8'd255, 32'hFFFF_FFFF,  32'd1,          1'b1, 1'b0},
        '{OP_LOAD,     1'b0, 8'd200, 8'd5,   32'd7,          32'd0,          1'b1, 1'b1},
        '{OP_LOAD,     1'b1, 8'd5,   8'd128, 32'd7,          32'd0,          1'b1, 1'b1},
        '{OP_DELTA,    1'b0, 8'd255, 8'd0,   32'd0,          32'd9,          1'b1, 1'b1},
        '{OP_TRADE,    1'b0, 8'd0,   8'd0,   32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_TRADE,    1'b1, 8'd0,   8'd0,   32'd0,          32'h8000_0000,  1'b1, 1'b1},
        '{OP_TOP_BIDS, 1'b0, 8'd0,   8'd0,   32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_TOP_ASKS, 1'b1, 8'd0,   8'd0,   32'd0,          32'hFFFF_FFFF,  1'b1, 1'b1},
        '{OP_SPARE_A,  1'b0, 8'd1,   8'd1,   32'd1,          32'd1,          1'b1, 1'b1},
        '{OP_SPARE_B,  1'b1, 8'd255, 8'd255, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 1'b1},
        '{OP_LOAD,     1'b0, 8'd127, 8'd0,   32'hFFFF_FFFF,  32'd0,          1'b0, 1'b0},
        '{OP_LOAD,     1'b0, 8'd0,   8'd0,   32'd1,          32'd0,          1'b0, 1'b0},
        '{OP_LOAD,     1'b1, 8'd0,   8'd0,   32'hFFFF_FFFF,  32'd0,          1'b0, 1'b0},
        '{OP_LOAD,     1'b1, 8'd0,   8'd127, 32'd5,          32'd0,          1'b0, 1'b0},
        '{OP_LOAD,     1'b0, 8'd0,   8'd0,   32'd0,          32'd0,          1'b0, 1'b0},
        '{OP_DELTA,    1'b0, 8'd127, 8'd0,   32'd0,          32'd1,          1'b0, 1'b0},
        '{OP_DELTA,    1'b1, 8'd0,   8'd50,  32'd0,          32'h7FFF_FFFF,  1'b0, 1'b0},
        '{OP_DELTA,    1'b1, 8'd0,   8'd50,  32'd0,          32'h8000_0001,  1'b0, 1'b0},
        '{OP_TRADE,    1'b0, 8'd0,   8'd0,   32'd0,          32'h7FFF_FFFF,  1'b0, 1'b0},
        '{OP_TRADE,    1'b1, 8'd0,   8'd0,   32'd0,          32'd1,          1'b0, 1'b0},
        '{OP_TRADE,    1'b1, 8'd20,  8'd0,   32'd0,          32'd3,          1'b0, 1'b0},
        '{OP_TRADE,    1'b1, 8'd130, 8'd0,   32'd0,          32'd3,          1'b0, 1'b0},
        '{OP_TOP_BIDS, 1'b0, 8'd0,   8'd0,   32'd0,          32'd100,        1'b0, 1'b0},
        '{OP_TOP_ASKS, 1'b1, 8'd0,   8'd0,   32'd0,          32'd64,         1'b0, 1'b0},
        '{OP_CLEAR,    1'b0, 8'd0,   8'd0,   32'd0,          32'd0,          1'b0, 1'b0},
        '{OP_TOP_BIDS, 1'b0, 8'd0,   8'd0,   32'd0,          32'h7FFF_FFFF,  1'b1, 1'b0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    logic [31:0] bid_qty [0:LEVELS-1];
    logic [31:0] ask_qty [0:LEVELS-1];
    logic [LEVELS-1:0] bid_marks;
    logic [LEVELS-1:0] ask_marks;

    t_out_word awaited_results [$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;

    price_level_order_book_top #(
        .PRICE_LEVELS (LEVELS),
        .MAX_DEPTH    (DEPTH_CAP)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void clear_book();
        for (int p = 0; p < LEVELS; p++) begin
            bid_qty[p] = '0;
            ask_qty[p] = '0;
        end
        bid_marks = '0;
        ask_marks = '0;
    endfunction

    function automatic t_out_word book_result(logic status, logic lvl_valid,
                                              logic [6:0] lvl_price, logic [31:0] lvl_qty,
                                              logic is_last);
        t_out_word r;
        r = '0;
        r.status      = status;
        r.level_valid = lvl_valid;
        r.level_price = lvl_price;
        r.level_qty   = lvl_qty;
        r.last        = is_last;
        for (int p = LEVELS - 1; p >= 0; p--) begin
            if (bid_marks[p]) begin
                r.best_bid_valid = 1'b1;
                r.best_bid_price = p[6:0];
                r.best_bid_qty   = bid_qty[p];
                break;
            end
        end
        for (int p = 0; p < LEVELS; p++) begin
            if (ask_marks[p]) begin
                r.best_ask_valid = 1'b1;
                r.best_ask_price = p[6:0];
                r.best_ask_qty   = ask_qty[p];
                break;
            end
        end
        return r;
    endfunction

    function automatic void predict_book(input t_in_word w, ref t_out_word outs[$]);
        logic [7:0]        px;
        logic [7:0]        tp;
        logic [31:0]       amt;
        logic [31:0]       level;
        logic [LEVELS-1:0] marks;
        logic              refused;
        int                total;
        int                cnt;
        int                p;
        px      = w.side ? w.ask_price : w.bid_price;
        tp      = w.side ? w.bid_price : w.ask_price;
        amt     = w.amount;
        refused = 1'b0;
        outs.delete();
        if (w.op == OP_TOP_BIDS || w.op == OP_TOP_ASKS) begin
            if (amt[31] || amt == 32'd0) begin
                outs.push_back(book_result(1'b1, 1'b0, 7'd0, 32'd0, 1'b1));
                return;
            end
            marks = (w.op == OP_TOP_BIDS) ? bid_marks : ask_marks;
            total = $countones(marks);
            if (amt < 32'(total)) total = int'(amt);
            if (total > DEPTH_CAP) total = DEPTH_CAP;
            if (total == 0) begin
                outs.push_back(book_result(1'b0, 1'b0, 7'd0, 32'd0, 1'b1));
                return;
            end
            cnt = 0;
            for (int i = 0; i < LEVELS && cnt < total; i++) begin
                p = (w.op == OP_TOP_BIDS) ? LEVELS - 1 - i : i;
                if (marks[p]) begin
                    level = (w.op == OP_TOP_BIDS) ? bid_qty[p] : ask_qty[p];
                    outs.push_back(book_result(1'b0, 1'b1, p[6:0], level, cnt == total - 1));
                    cnt++;
                end
            end
            return;
        end
        case (w.op)
            OP_CLEAR: begin
                clear_book();
            end
            OP_LOAD: begin
                if (px >= 8'(LEVELS)) begin
                    refused = 1'b1;
                end else if (w.side) begin
                    ask_qty[px[6:0]] = w.qty;
                    if (w.qty != 32'd0) ask_marks[px[6:0]] = 1'b1;
                end else begin
                    bid_qty[px[6:0]] = w.qty;
                    if (w.qty != 32'd0) bid_marks[px[6:0]] = 1'b1;
                end
            end
            OP_DELTA: begin
                if (px >= 8'(LEVELS)) begin
                    refused = 1'b1;
                end else if (w.side) begin
                    ask_qty[px[6:0]] = ask_qty[px[6:0]] + amt;
                    ask_marks[px[6:0]] = (ask_qty[px[6:0]] != 32'd0);
                end else begin
                    bid_qty[px[6:0]] = bid_qty[px[6:0]] + amt;
                    bid_marks[px[6:0]] = (bid_qty[px[6:0]] != 32'd0);
                end
            end
            OP_TRADE: begin
                if (amt[31] || amt == 32'd0 || tp >= 8'(LEVELS)) begin
                    refused = 1'b1;
                end else if (w.side) begin
                    bid_qty[tp[6:0]] = bid_qty[tp[6:0]] - amt;
                    if (bid_qty[tp[6:0]] == 32'd0) bid_marks[tp[6:0]] = 1'b0;
                end else begin
                    ask_qty[tp[6:0]] = ask_qty[tp[6:0]] - amt;
                    if (ask_qty[tp[6:0]] == 32'd0) ask_marks[tp[6:0]] = 1'b0;
                end
            end
            default: begin
                refused = 1'b1;
            end
        endcase
        outs.push_back(book_result(refused, 1'b0, 7'd0, 32'd0, 1'b1));
    endfunction

    function automatic logic [7:0] pick_price();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 8'($urandom_range(0, 7));
        if (r < 60) return 8'($urandom_range(120, 127));
        if (r < 88) return 8'($urandom_range(0, 127));
        return 8'($urandom_range(128, 255));
    endfunction

    function automatic t_in_word noise_word();
        t_in_word w;
        w.op        = 3'($urandom_range(0, 7));
        w.side      = 1'($urandom_range(0, 1));
        w.bid_price = 8'($urandom_range(0, 255));
        w.ask_price = 8'($urandom_range(0, 255));
        w.qty       = $urandom;
        w.amount    = $urandom;
        return w;
    endfunction

    function automatic logic [31:0] load_qty();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 32'd0;
        if (r < 25) return 32'hFFFF_FFFF;
        if (r < 70) return 32'($urandom_range(1, 1000));
        return $urandom;
    endfunction

    function automatic t_in_word snapshot_level();
        t_in_word w;
        w = noise_word();
        w.op = OP_LOAD;
        w.bid_price = 8'($urandom_range(0, 127));
        w.ask_price = 8'($urandom_range(0, 127));
        w.qty = load_qty();
        return w;
    endfunction

    function automatic t_in_word random_word();
        t_in_word    w;
        logic [7:0]  px;
        logic [31:0] level;
        int          r;
        int          k;
        w = noise_word();
        w.bid_price = pick_price();
        w.ask_price = pick_price();
        r = $urandom_range(99);
        k = $urandom_range(99);
        if (r < 28) begin
            w.op  = OP_LOAD;
            w.qty = load_qty();
        end else if (r < 53) begin
            w.op  = OP_DELTA;
            px    = w.side ? w.ask_price : w.bid_price;
            level = w.side ? ask_qty[px[6:0]] : bid_qty[px[6:0]];
            if (k < 35)      w.amount = $urandom_range(0, 200) - 100;
            else if (k < 60) w.amount = 32'd0 - level;
            else if (k < 80) w.amount = $urandom;
            else             w.amount = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        end else if (r < 75) begin
            w.op  = OP_TRADE;
            px    = w.side ? w.bid_price : w.ask_price;
            level = w.side ? bid_qty[px[6:0]] : ask_qty[px[6:0]];
            if (k < 40)      w.amount = $urandom_range(1, 50);
            else if (k < 60) w.amount = level;
            else if (k < 75) w.amount = $urandom;
            else if (k < 85) w.amount = 32'd0;
            else             w.amount = 32'h7FFF_FFFF;
        end else if (r < 93) begin
            w.op = r[0] ? OP_TOP_BIDS : OP_TOP_ASKS;
            if (k < 70)      w.amount = $urandom_range(1, 8);
            else if (k < 80) w.amount = $urandom_range(9, 64);
            else if (k < 86) w.amount = $urandom_range(65, 32'h7FFF_FFFF);
            else if (k < 93) w.amount = 32'd0;
            else             w.amount = $urandom | 32'h8000_0000;
        end else if (r < 96) begin
            w.op = r[0] ? OP_SPARE_A : OP_SPARE_B;
        end else begin
            w.op = OP_CLEAR;
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        t_out_word outs [$];
        if (!steady && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        predict_book(w, outs);
        if (typed) begin
            awaited_results.push_back(want);
        end else begin
            foreach (outs[n]) awaited_results.push_back(outs[n]);
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 60) $display("MISMATCH at result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (awaited_results.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
            return;
        end
        want = awaited_results.pop_front();
        check_field("status",         32'(got.status),         32'(want.status));
        check_field("level_valid",    32'(got.level_valid),    32'(want.level_valid));
        check_field("level_price",    32'(got.level_price),    32'(want.level_price));
        check_field("level_qty",      got.level_qty,           want.level_qty);
        check_field("best_bid_valid", 32'(got.best_bid_valid), 32'(want.best_bid_valid));
        check_field("best_bid_price", 32'(got.best_bid_price), 32'(want.best_bid_price));
        check_field("best_bid_qty",   got.best_bid_qty,        want.best_bid_qty);
        check_field("best_ask_valid", 32'(got.best_ask_valid), 32'(want.best_ask_valid));
        check_field("best_ask_price", 32'(got.best_ask_price), 32'(want.best_ask_price));
        check_field("best_ask_qty",   got.best_ask_qty,        want.best_ask_qty);
        check_field("last",           32'(got.last),           32'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            check_result(o_out_word);
        end
        i_out_ready <= steady || ($urandom_range(99) >= 10);
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("price_level_order_book_top test failed");
            $finish;
        end
    end

    initial begin
        t_in_word  w;
        t_out_word want;
        int        base;
        clear_book();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (book_script[k]) begin
            w.op        = book_script[k].op;
            w.side      = book_script[k].side;
            w.bid_price = book_script[k].bid_price;
            w.ask_price = book_script[k].ask_price;
            w.qty       = book_script[k].qty;
            w.amount    = book_script[k].amount;
            want        = '0;
            want.status = book_script[k].typed_status;
            want.last   = 1'b1;
            send_word(w, book_script[k].typed, want);
        end

        // Random part: mostly single updates and queries on a few busy prices, with
        // occasional snapshots sent as a clear followed by a run of level loads.
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            steady <= (items_sent - base >= 90) && (items_sent - base < 150);
            if ($urandom_range(99) < 8) begin
                w = noise_word();
                w.op = OP_CLEAR;
                send_word(w, 1'b0, '0);
                repeat ($urandom_range(2, 8)) send_word(snapshot_level(), 1'b0, '0);
            end else begin
                send_word(random_word(), 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("price_level_order_book_top test passed");
        end else begin
            $display("price_level_order_book_top test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/plob_pkg.sv
hdl/plob_ram.sv
hdl/plob_best.sv
hdl/price_level_order_book_top.sv
sim/tb_price_level_order_book_top.sv
